/* hdl/bmtc_pkg.sv */
// Shared types and constants for the bit-matrix transitive closure core.
// Used by bit_matrix_transitive_closure_core and its testbench; depends on nothing.
package bmtc_pkg;

  localparam int MAX_NODES_DEF  = 128;
  localparam int NODE_W         = 7;
  localparam int COUNT_W        = 8;
  localparam int NODE_COUNT_RST = 128;

  localparam logic [1:0] OP_CLEAR = 2'd0;
  localparam logic [1:0] OP_ADD   = 2'd1;
  localparam logic [1:0] OP_CLOSE = 2'd2;
  localparam logic [1:0] OP_QUERY = 2'd3;

  typedef struct packed {
    logic [1:0]        opcode;
    logic [NODE_W-1:0] src_node;
    logic [NODE_W-1:0] dst_node;
  } in_t;

  typedef struct packed {
    logic reachable;
    logic status;
  } out_t;

endpackage

/* hdl/bmtc_ram.sv */
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Used for the adjacency and reachability matrices; no package dependency.
module bmtc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* hdl/bit_matrix_transitive_closure_core.sv */
// Directed-graph reachability engine over two bit-matrix RAMs (adjacency and
// reachability), one row of MAX_NODES bits per node; depends on bmtc_pkg and bmtc_ram.
// One transaction is processed at a time and each yields exactly one result.
// With n the effective node count: add edge sets one adjacency bit; query reads one
// reachability bit; clear zeroes all MAX_NODES rows of both matrices; closure copies
// the first n adjacency rows with diagonals set, then per pivot ORs the pivot row into
// each row that reaches it, using the single row-OR unit that reads one reachability
// row per cycle through the RAM read port; results are registered. After reset a
// clearing pass precedes any input; configuration writes are accepted at any time.
module bit_matrix_transitive_closure_core #(
  parameter int MAX_NODES = bmtc_pkg::MAX_NODES_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  bmtc_pkg::in_t                in_data,
  output logic                         out_valid,
  input  logic                         out_stall,
  output bmtc_pkg::out_t               out_data,
  input  logic                         cfg_we,
  input  logic [bmtc_pkg::COUNT_W-1:0] cfg_wdata
);

  localparam int ROW_W  = MAX_NODES;
  localparam int ROW_AW = $clog2(MAX_NODES);
  localparam int CNT_W  = $clog2(MAX_NODES + 1);
  localparam int CMP_W  = (CNT_W > bmtc_pkg::COUNT_W) ? CNT_W : bmtc_pkg::COUNT_W;

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_CLR   = 4'd1;
  localparam logic [3:0] ST_ADD   = 4'd2;
  localparam logic [3:0] ST_QRY   = 4'd3;
  localparam logic [3:0] ST_CP_RD = 4'd4;
  localparam logic [3:0] ST_CP_WR = 4'd5;
  localparam logic [3:0] ST_PV_RD = 4'd6;
  localparam logic [3:0] ST_PV_LD = 4'd7;
  localparam logic [3:0] ST_RW    = 4'd8;
  localparam logic [3:0] ST_DONE  = 4'd9;

  logic [3:0]                   state_r, state_nxt;
  logic [ROW_AW-1:0]            cnt_r, cnt_nxt;
  logic [ROW_AW-1:0]            k_r, k_nxt;
  logic [ROW_AW-1:0]            src_r, src_nxt;
  logic [ROW_AW-1:0]            dst_r, dst_nxt;
  logic [ROW_W-1:0]             row_k_r, row_k_nxt;
  bmtc_pkg::out_t               res_r, res_nxt;
  logic                         clr_op_r, clr_op_nxt;
  logic                         out_valid_r, out_valid_nxt;
  bmtc_pkg::out_t               out_data_r, out_data_nxt;
  logic [bmtc_pkg::COUNT_W-1:0] node_count_r;

  logic                         adj_we, adj_re, reach_we, reach_re;
  logic [ROW_AW-1:0]            adj_waddr, adj_raddr, reach_waddr, reach_raddr;
  logic [ROW_W-1:0]             adj_wdata, adj_rdata, reach_wdata, reach_rdata;

  logic [CMP_W-1:0]             cnt_ext, n_eff, n_last, src_ext, dst_ext;
  logic                         bad, n_zero, in_acc, cnt_last, k_last;
  logic [ROW_AW-1:0]            cnt_inc;

  // Effective node count saturates at the matrix size.
  assign cnt_ext = CMP_W'(node_count_r);
  assign n_eff   = (cnt_ext > CMP_W'(MAX_NODES)) ? CMP_W'(MAX_NODES) : cnt_ext;
  assign n_last  = n_eff - CMP_W'(1);
  assign n_zero  = (n_eff == '0);
  assign src_ext = CMP_W'(in_data.src_node);
  assign dst_ext = CMP_W'(in_data.dst_node);
  assign bad     = (src_ext >= n_eff) || (dst_ext >= n_eff);

  assign in_stall = (state_r != ST_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign cnt_last = (CMP_W'(cnt_r) == n_last);
  assign k_last   = (CMP_W'(k_r) == n_last);
  assign cnt_inc  = ROW_AW'(cnt_r + 1'b1);

  bmtc_ram #(.WIDTH(ROW_W), .DEPTH(MAX_NODES)) u_adj_ram (
    .clk   (clk),
    .we    (adj_we),
    .waddr (adj_waddr),
    .wdata (adj_wdata),
    .re    (adj_re),
    .raddr (adj_raddr),
    .rdata (adj_rdata)
  );

  bmtc_ram #(.WIDTH(ROW_W), .DEPTH(MAX_NODES)) u_reach_ram (
    .clk   (clk),
    .we    (reach_we),
    .waddr (reach_waddr),
    .wdata (reach_wdata),
    .re    (reach_re),
    .raddr (reach_raddr),
    .rdata (reach_rdata)
  );

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    k_nxt         = k_r;
    src_nxt       = src_r;
    dst_nxt       = dst_r;
    row_k_nxt     = row_k_r;
    res_nxt       = res_r;
    clr_op_nxt    = clr_op_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    adj_we        = 1'b0;
    adj_waddr     = cnt_r;
    adj_wdata     = '0;
    adj_re        = 1'b0;
    adj_raddr     = cnt_r;
    reach_we      = 1'b0;
    reach_waddr   = cnt_r;
    reach_wdata   = '0;
    reach_re      = 1'b0;
    reach_raddr   = cnt_r;

    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          res_nxt = '0;
          src_nxt = src_ext[ROW_AW-1:0];
          dst_nxt = dst_ext[ROW_AW-1:0];
          case (in_data.opcode)
            bmtc_pkg::OP_CLEAR: begin
              cnt_nxt    = '0;
              clr_op_nxt = 1'b1;
              state_nxt  = ST_CLR;
            end
            bmtc_pkg::OP_ADD: begin
              if (bad) begin
                res_nxt.status = 1'b1;
                state_nxt      = ST_DONE;
              end else begin
                adj_re    = 1'b1;
                adj_raddr = src_ext[ROW_AW-1:0];
                state_nxt = ST_ADD;
              end
            end
            bmtc_pkg::OP_CLOSE: begin
              cnt_nxt   = '0;
              state_nxt = n_zero ? ST_DONE : ST_CP_RD;
            end
            bmtc_pkg::OP_QUERY: begin
              if (bad) begin
                res_nxt.status = 1'b1;
                state_nxt      = ST_DONE;
              end else begin
                reach_re    = 1'b1;
                reach_raddr = src_ext[ROW_AW-1:0];
                state_nxt   = ST_QRY;
              end
            end
            default: begin
              state_nxt = ST_DONE;
            end
          endcase
        end
      end
      ST_CLR: begin
        adj_we   = 1'b1;
        reach_we = 1'b1;
        if (cnt_r == ROW_AW'(MAX_NODES - 1)) begin
          state_nxt = clr_op_r ? ST_DONE : ST_IDLE;
        end else begin
          cnt_nxt = cnt_inc;
        end
      end
      ST_ADD: begin
        adj_we    = 1'b1;
        adj_waddr = src_r;
        adj_wdata = adj_rdata | (ROW_W'(1) << dst_r);
        state_nxt = ST_DONE;
      end
      ST_QRY: begin
        res_nxt.reachable = reach_rdata[dst_r];
        state_nxt         = ST_DONE;
      end
      ST_CP_RD: begin
        adj_re    = 1'b1;
        state_nxt = ST_CP_WR;
      end
      ST_CP_WR: begin
        // Copy one adjacency row and set its diagonal bit, while the next row is read.
        reach_we    = 1'b1;
        reach_wdata = adj_rdata | (ROW_W'(1) << cnt_r);
        if (cnt_last) begin
          k_nxt     = '0;
          state_nxt = ST_PV_RD;
        end else begin
          adj_re    = 1'b1;
          adj_raddr = cnt_inc;
          cnt_nxt   = cnt_inc;
        end
      end
      ST_PV_RD: begin
        reach_re    = 1'b1;
        reach_raddr = k_r;
        state_nxt   = ST_PV_LD;
      end
      ST_PV_LD: begin
        row_k_nxt   = reach_rdata;
        reach_re    = 1'b1;
        reach_raddr = '0;
        cnt_nxt     = '0;
        state_nxt   = ST_RW;
      end
      ST_RW: begin
        // The pivot row cannot change during its own pass, so the cached copy stays exact.
        if (reach_rdata[k_r]) begin
          reach_we    = 1'b1;
          reach_wdata = reach_rdata | row_k_r;
        end
        if (cnt_last) begin
          if (k_last) begin
            state_nxt = ST_DONE;
          end else begin
            k_nxt     = ROW_AW'(k_r + 1'b1);
            state_nxt = ST_PV_RD;
          end
        end else begin
          reach_re    = 1'b1;
          reach_raddr = cnt_inc;
          cnt_nxt     = cnt_inc;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = res_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_CLR;
      cnt_r        <= '0;
      clr_op_r     <= 1'b0;
      out_valid_r  <= 1'b0;
      node_count_r <= bmtc_pkg::COUNT_W'(bmtc_pkg::NODE_COUNT_RST);
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      clr_op_r    <= clr_op_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        node_count_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    k_r        <= k_nxt;
    src_r      <= src_nxt;
    dst_r      <= dst_nxt;
    row_k_r    <= row_k_nxt;
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTHESIS
  a_no_reach_on_error: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_data_r.reachable && out_data_r.status))
    else $error("result carries both a reachable bit and an error status");

  a_row_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CP_WR || state_r == ST_RW) |-> (CMP_W'(cnt_r) < n_eff))
    else $error("closure row counter ran past the node count");

  a_pivot_row_stable: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RW && reach_we && reach_waddr == k_r) |-> (reach_wdata == row_k_r))
    else $error("pivot row was modified during its own pass");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> in_stall)
    else $error("a second transaction was accepted before the first finished");

  a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == ST_DONE))
    else $error("result raised outside the completion state");
`endif

endmodule

/* tb/sv/bit_matrix_transitive_closure_core_test.sv */
// Self-checking testbench for bit_matrix_transitive_closure_core: directed and
// random graph traffic, checked against a built-in reachability predictor.
// Depends on bmtc_pkg and the core RTL only.
`timescale 1ns / 100ps

module bit_matrix_transitive_closure_core_test;

  localparam int MAXN        = bmtc_pkg::MAX_NODES_DEF;
  localparam int QUIET_LIMIT = 60000;

  logic           clk       = 1'b0;
  logic           rst_n     = 1'b0;
  logic           in_valid  = 1'b0;
  logic           in_stall;
  bmtc_pkg::in_t  in_data   = '0;
  logic           out_valid;
  logic           out_stall = 1'b0;
  bmtc_pkg::out_t out_data;
  logic           cfg_we    = 1'b0;
  logic [bmtc_pkg::COUNT_W-1:0] cfg_wdata = '0;

  bit_matrix_transitive_closure_core DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Predictor state: adjacency and reachability matrices plus the node count.
  bit [MAXN-1:0]      adj_rows   [MAXN];
  bit [MAXN-1:0]      reach_rows [MAXN];
  logic [bmtc_pkg::COUNT_W-1:0] node_limit = bmtc_pkg::COUNT_W'(bmtc_pkg::NODE_COUNT_RST);

  bmtc_pkg::in_t  pending_requests [$];
  bmtc_pkg::out_t expected_answers [$];
  int   requests_queued  = 0;
  int   answers_checked  = 0;
  int   mismatch_count   = 0;
  int   quiet_cycles     = 0;
  logic in_taken         = 1'b0;

  function automatic bmtc_pkg::out_t graph_answer(bmtc_pkg::in_t req);
    bmtc_pkg::out_t res;
    int   n;
    bit   bad;
    n   = (int'(node_limit) > MAXN) ? MAXN : int'(node_limit);
    bad = (req.src_node >= n) || (req.dst_node >= n);
    res = '0;
    case (req.opcode)
      bmtc_pkg::OP_CLEAR: begin
        for (int r = 0; r < MAXN; r++) begin
          adj_rows[r]   = '0;
          reach_rows[r] = '0;
        end
      end
      bmtc_pkg::OP_ADD: begin
        if (bad) res.status = 1'b1;
        else adj_rows[req.src_node][req.dst_node] = 1'b1;
      end
      bmtc_pkg::OP_CLOSE: begin
        for (int i = 0; i < n; i++) begin
          reach_rows[i]    = adj_rows[i];
          reach_rows[i][i] = 1'b1;
        end
        // Warshall: rows at or above n keep whatever an earlier closure left.
        for (int k = 0; k < n; k++)
          for (int i = 0; i < n; i++)
            if (reach_rows[i][k]) reach_rows[i] |= reach_rows[k];
      end
      default: begin
        if (bad) res.status = 1'b1;
        else res.reachable = reach_rows[req.src_node][req.dst_node];
      end
    endcase
    return res;
  endfunction

  // Input and output monitor; predictions are made at the accepting edge.
  always @(posedge clk) begin
    bmtc_pkg::out_t want;
    in_taken <= rst_n && in_valid && !in_stall;
    if (rst_n && in_valid && !in_stall) expected_answers.push_back(graph_answer(in_data));
    if (rst_n && out_valid && !out_stall) begin
      answers_checked++;
      if (expected_answers.size() == 0) begin
        $error("result with no transaction pending: reachable=%0b status=%0b",
               out_data.reachable, out_data.status);
        mismatch_count++;
      end else begin
        want = expected_answers.pop_front();
        if (out_data.reachable !== want.reachable) begin
          $error("reachable: expected %0b, actual %0b", want.reachable, out_data.reachable);
          mismatch_count++;
        end
        if (out_data.status !== want.status) begin
          $error("status: expected %0b, actual %0b", want.status, out_data.status);
          mismatch_count++;
        end
      end
    end
    if (rst_n && cfg_we) node_limit = cfg_wdata;
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("bit_matrix_transitive_closure_core_test failed");
      $finish;
    end
  end

  // Sender: bursts of random length separated by random gaps.
  int burst_left = 1;
  int gap_left   = 0;

  always @(negedge clk) begin
    logic          next_valid;
    bmtc_pkg::in_t next_data;
    if (rst_n && (!in_valid || in_taken)) begin
      next_valid = 1'b0;
      next_data  = in_data;
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
      end else if (pending_requests.size() > 0) begin
        next_valid = 1'b1;
        next_data  = pending_requests.pop_front();
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 24);
          gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
        end else begin
          burst_left <= burst_left - 1;
        end
      end
      in_valid <= next_valid;
      in_data  <= next_data;
    end
  end

  // Receiver: stall pattern that changes mode now and then, plus one long hold-off.
  int   hold_left  = 0;
  bit   hold_done  = 1'b0;
  int   mode_left  = 0;
  int   stall_mode = 0;

  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (!hold_done && answers_checked >= 200) begin
      out_stall <= 1'b1;
      hold_left <= 400;
      hold_done <= 1'b1;
    end else begin
      if (mode_left == 0) begin
        stall_mode <= $urandom_range(0, 3);
        mode_left  <= $urandom_range(20, 200);
      end else begin
        mode_left <= mode_left - 1;
      end
      case (stall_mode)
        0:       out_stall <= 1'b0;
        1:       out_stall <= ($urandom_range(0, 1) == 1);
        2:       out_stall <= (mode_left % 4 == 0);
        default: out_stall <= ($urandom_range(0, 3) != 0);
      endcase
    end
  end

  task automatic queue_request(input logic [1:0] op, input int src, input int dst);
    bmtc_pkg::in_t req;
    req.opcode   = op;
    req.src_node = bmtc_pkg::NODE_W'(src);
    req.dst_node = bmtc_pkg::NODE_W'(dst);
    pending_requests.push_back(req);
    requests_queued++;
  endtask

  task automatic wait_idle();
    do @(negedge clk);
    while (pending_requests.size() != 0 || in_valid || expected_answers.size() != 0);
    repeat (4) @(negedge clk);
  endtask

  task automatic set_node_count(input int value);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_wdata <= bmtc_pkg::COUNT_W'(value);
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Mostly nodes from a small window so that paths form; now and then any index.
  function automatic int pick_node(input int base, input int span);
    if ($urandom_range(0, 9) == 0) return $urandom_range(0, 127);
    return base + $urandom_range(0, span - 1);
  endfunction

  int phase_counts [15] = '{1, 2, 3, 5, 8, 13, 16, 0, 32, 64, 129, 7, 100, 128, 255};

  initial begin
    int         n;
    int         span;
    int         base;
    int         target;
    logic [1:0] op;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: empty matrix, word-crossing edges, full range, then small, zero and oversized counts.
    set_node_count(128);
    queue_request(bmtc_pkg::OP_QUERY, 0, 0);
    queue_request(bmtc_pkg::OP_ADD, 0, 127);
    queue_request(bmtc_pkg::OP_ADD, 127, 0);
    queue_request(bmtc_pkg::OP_ADD, 0, 1);
    queue_request(bmtc_pkg::OP_ADD, 1, 63);
    queue_request(bmtc_pkg::OP_ADD, 63, 64);
    queue_request(bmtc_pkg::OP_CLOSE, 5, 9);
    queue_request(bmtc_pkg::OP_QUERY, 0, 0);
    queue_request(bmtc_pkg::OP_QUERY, 127, 64);
    queue_request(bmtc_pkg::OP_QUERY, 64, 0);
    queue_request(bmtc_pkg::OP_QUERY, 127, 127);
    set_node_count(4);
    queue_request(bmtc_pkg::OP_ADD, 3, 4);
    queue_request(bmtc_pkg::OP_QUERY, 0, 127);
    queue_request(bmtc_pkg::OP_ADD, 2, 3);
    queue_request(bmtc_pkg::OP_CLOSE, 0, 0);
    queue_request(bmtc_pkg::OP_QUERY, 2, 3);
    // Row 127 was outside the last closure and must still hold its old bits.
    set_node_count(128);
    queue_request(bmtc_pkg::OP_QUERY, 127, 64);
    queue_request(bmtc_pkg::OP_CLEAR, 127, 127);
    queue_request(bmtc_pkg::OP_QUERY, 127, 64);
    set_node_count(0);
    queue_request(bmtc_pkg::OP_ADD, 0, 0);
    queue_request(bmtc_pkg::OP_CLOSE, 0, 0);
    queue_request(bmtc_pkg::OP_QUERY, 0, 0);
    set_node_count(255);
    queue_request(bmtc_pkg::OP_ADD, 127, 127);
    queue_request(bmtc_pkg::OP_CLOSE, 0, 0);
    queue_request(bmtc_pkg::OP_QUERY, 127, 127);

    // Random: clear, edges, closure, queries, with some noise mixed in.
    foreach (phase_counts[p]) begin
      set_node_count(phase_counts[p]);
      n      = (phase_counts[p] > MAXN) ? MAXN : phase_counts[p];
      target = requests_queued + ((n >= 64) ? 60 : 120);
      while (requests_queued < target) begin
        if ($urandom_range(0, 3) == 0)
          queue_request(bmtc_pkg::OP_CLEAR, $urandom_range(0, 127), $urandom_range(0, 127));
        span = (n == 0) ? 1 : $urandom_range(1, (n < 12) ? n : 12);
        base = $urandom_range(0, (n > span) ? n - span : 0);
        repeat ($urandom_range(0, 2 * span))
          queue_request(bmtc_pkg::OP_ADD, pick_node(base, span), pick_node(base, span));
        if ($urandom_range(0, 7) == 0) begin
          op = 2'($urandom_range(0, 3));
          // No extra noise closures on graphs above 16 nodes.
          if (op == bmtc_pkg::OP_CLOSE && n > 16) op = bmtc_pkg::OP_QUERY;
          queue_request(op, $urandom_range(0, 127), $urandom_range(0, 127));
        end
        queue_request(bmtc_pkg::OP_CLOSE, $urandom_range(0, 127), $urandom_range(0, 127));
        repeat ($urandom_range(1, 12))
          queue_request(bmtc_pkg::OP_QUERY, pick_node(base, span), pick_node(base, span));
      end
    end

    wait_idle();
    repeat (20) @(negedge clk);
    if (mismatch_count == 0 && expected_answers.size() == 0)
      $display("bit_matrix_transitive_closure_core_test passed");
    else
      $display("bit_matrix_transitive_closure_core_test failed");
    $finish;
  end

endmodule
